// ----- src/lcc_pkg.sv -----
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants for the layered character display compositor.
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int LYR_W = 3;   // layer field / counter width
  localparam int COL_W = 6;   // column counter width, holds up to 64 columns

  localparam logic [7:0] RESET_CHAR = 8'h20;
  localparam logic [6:0] ROW2_BASE  = 7'h40;
  localparam logic [8:0] DD_ADDR    = 9'h080;
  localparam logic [8:0] DATA_RS    = 9'h100;
  localparam logic [8:0] ON_OFF     = 9'h008;
  localparam logic [8:0] DISP_ON    = 9'h004;

  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_CLR_LYR = 3'd1;
  localparam logic [2:0] CMD_CLR_LN  = 3'd2;
  localparam logic [2:0] CMD_SET_CUR = 3'd3;
  localparam logic [2:0] CMD_HIDE    = 3'd4;
  localparam logic [2:0] CMD_SHOW    = 3'd5;
  localparam logic [2:0] CMD_TOGGLE  = 3'd6;
  localparam logic [2:0] CMD_REFRESH = 3'd7;

  typedef enum logic [1:0] {WS_CODE, WS_TRANS, WS_INIT} wsrc_t;
  typedef enum logic [1:0] {HID_NONE, HID_SET, HID_CLR, HID_FLIP} hid_op_t;
  typedef enum logic [2:0] {
    EK_STATUS, EK_ROWADDR, EK_ADDR, EK_DATA, EK_CURSOR, EK_MODE
  } emit_kind_t;

  typedef struct packed {
    logic              lm_rd;
    logic              lm_wr;
    wsrc_t             wsrc;
    logic              sh_wr;
    logic              sh_init;
    logic [LYR_W-1:0]  lyr;
    logic              row;
    logic [COL_W-1:0]  col;
    logic [7:0]        code;
    logic              acc_en;
    logic              acc_first;
    hid_op_t           hid_op;
    logic              cur_wr;
    logic              cur_on;
    logic              cur_blink;
    logic              cur_upd;
    logic              emit;
    emit_kind_t        kind;
    logic              status;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;   // output register full and not being taken
    logic diff;   // composed char differs from shown char
  } dp_stat_t;

endpackage

// ----- src/layered_char_lcd_compositor_top.sv -----
// ----------------------------------------------------------------------------
// layered_char_lcd_compositor_top
// Layered two-row character compositor producing HD44780-style words.
//
//  channel  dir  handshake           payload
//  in       in   in_tvalid/tready    in_tdata: command item
//  out      out  out_tvalid/tready   out_tdata, out_tlast
//  cfg      in   cfg_we              cfg_wdata: transparent code
//
// After reset a sweep over all LAYERS*2*COLS entries fills the stores; no
// item is taken meanwhile. A layer clear writes 2*COLS entries, a line clear
// COLS. Refresh reads every layer in turn for each of the 2*COLS positions
// and emits data words only for changed characters. A stalled out side holds
// the sequencer; one item is in work at a time.
// ----------------------------------------------------------------------------
module layered_char_lcd_compositor_top
  import lcc_pkg::*;
#(
  parameter int LAYERS = 4,
  parameter int COLS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[2:0] layer[5:3] row[7:6] col[12:8] char_code[20:13]
  // cursor_on[21] cursor_blink[22], zero pad
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // lcd_word[8:0] word_valid[9] status[10], zero pad
  output logic [15:0] out_tdata,
  output logic        out_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lcc_ctrl #(.LAYERS(LAYERS), .COLS(COLS)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .stat, .cmd
  );

  lcc_dp #(.LAYERS(LAYERS), .COLS(COLS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .cmd, .stat,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

// ----- src/lcc_dp.sv -----
// ----------------------------------------------------------------------------
// lcc_dp
// Datapath: layer and shown-char memories, flags, cursors, compositing
// accumulator and the output register.
// ----------------------------------------------------------------------------
module lcc_dp
  import lcc_pkg::*;
#(
  parameter int LAYERS = 4,
  parameter int COLS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast
);

  localparam int DEPTH = LAYERS * 2 * COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (2 * COLS > 1) ? $clog2(2 * COLS) : 1;
  localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  logic [7:0] lm [DEPTH];
  logic [7:0] sh [2*COLS];

  logic [7:0]       trans_r;
  logic [7:0]       lm_q_r, sh_q_r, acc_r;
  logic [LAYERS-1:0] hid_r;
  logic             crow_r [LAYERS];
  logic [COL_W-1:0] ccol_r [LAYERS];
  logic             con_r  [LAYERS];
  logic             cblk_r [LAYERS];
  logic             comp_row_r, comp_on_r, comp_blk_r;
  logic [COL_W-1:0] comp_col_r;
  logic             ov_r, olast_r;
  logic [10:0]      od_r;

  logic [9:0]    la;
  logic [6:0]    sa;
  logic [AW-1:0] lm_addr;
  logic [SW-1:0] sh_addr;
  logic [LW-1:0] li;
  logic [7:0]    wdata, acc_base, acc_nxt;
  logic          any_vis;
  logic [LW-1:0] top_l;
  logic [8:0]    word;
  logic [6:0]    cur_addr;

  assign la      = 10'(cmd.lyr) * 10'(2 * COLS) + 10'(cmd.row) * 10'(COLS) + 10'(cmd.col);
  assign sa      = 7'(cmd.row) * 7'(COLS) + 7'(cmd.col);
  assign lm_addr = la[AW-1:0];
  assign sh_addr = sa[SW-1:0];
  assign li      = cmd.lyr[LW-1:0];

  always_comb begin
    case (cmd.wsrc)
      WS_CODE:  wdata = cmd.code;
      WS_TRANS: wdata = trans_r;
      default:  wdata = RESET_CHAR;
    endcase
  end

  always_comb begin
    acc_base = cmd.acc_first ? trans_r : acc_r;
    acc_nxt  = acc_base;
    if (!hid_r[li] && lm_q_r != trans_r) acc_nxt = lm_q_r;
  end

  always_comb begin
    any_vis = 1'b0;
    top_l   = '0;
    for (int i = 0; i < LAYERS; i++) begin
      if (!hid_r[i]) begin
        any_vis = 1'b1;
        top_l   = LW'(i);
      end
    end
  end

  assign cur_addr = (comp_row_r ? ROW2_BASE : 7'h00) + 7'(comp_col_r);

  always_comb begin
    case (cmd.kind)
      EK_ROWADDR: word = DD_ADDR | (cmd.row ? {2'b00, ROW2_BASE} : 9'h000);
      EK_ADDR:    word = DD_ADDR | {2'b00, (cmd.row ? ROW2_BASE : 7'h00) + 7'(cmd.col)};
      EK_DATA:    word = DATA_RS | {1'b0, acc_r};
      EK_CURSOR:  word = DD_ADDR | {2'b00, cur_addr};
      EK_MODE:    word = ON_OFF | DISP_ON | {7'd0, comp_on_r, comp_blk_r};
      default:    word = '0;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.lm_wr) lm[lm_addr] <= wdata;
    if (cmd.lm_rd) begin
      lm_q_r <= lm[lm_addr];
      sh_q_r <= sh[sh_addr];
    end
    if (cmd.sh_wr) sh[sh_addr] <= cmd.sh_init ? RESET_CHAR : acc_r;
    if (cmd.acc_en) acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_r    <= RESET_CHAR;
      hid_r      <= '0;
      comp_row_r <= 1'b0;
      comp_col_r <= '0;
      comp_on_r  <= 1'b0;
      comp_blk_r <= 1'b0;
      ov_r       <= 1'b0;
      olast_r    <= 1'b0;
      for (int i = 0; i < LAYERS; i++) begin
        crow_r[i] <= 1'b0;
        ccol_r[i] <= '0;
        con_r[i]  <= 1'b0;
        cblk_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) trans_r <= cfg_wdata;
      case (cmd.hid_op)
        HID_SET:  hid_r[li] <= 1'b1;
        HID_CLR:  hid_r[li] <= 1'b0;
        HID_FLIP: hid_r[li] <= ~hid_r[li];
        default:  ;
      endcase
      if (cmd.cur_wr) begin
        crow_r[li] <= cmd.row;
        ccol_r[li] <= cmd.col;
        con_r[li]  <= cmd.cur_on;
        cblk_r[li] <= cmd.cur_blink;
      end
      if (cmd.cur_upd) begin
        if (any_vis) begin
          comp_row_r <= crow_r[top_l];
          comp_col_r <= ccol_r[top_l];
          comp_on_r  <= con_r[top_l];
          comp_blk_r <= cblk_r[top_l];
        end else begin
          comp_on_r  <= 1'b0;
          comp_blk_r <= 1'b0;
        end
      end
      if (cmd.emit) begin
        ov_r    <= 1'b1;
        olast_r <= cmd.last;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) od_r <= {cmd.status, cmd.kind != EK_STATUS, word};
  end

  assign stat.busy  = ov_r & ~out_tready;
  assign stat.diff  = sh_q_r != acc_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, od_r};
  assign out_tlast  = olast_r;

endmodule

// ----- src/lcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcc_ctrl
// Controller: command decode, clearing sweeps and the refresh sequencer.
// ----------------------------------------------------------------------------
module lcc_ctrl
  import lcc_pkg::*;
#(
  parameter int LAYERS = 4,
  parameter int COLS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  input  dp_stat_t    stat,
  output dp_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_EXEC, S_CLR, S_STAT, S_RADDR, S_RD, S_ACC,
    S_CMP, S_SKIPA, S_DATA, S_NEXT, S_CUR, S_MODE
  } state_t;

  localparam logic [LYR_W-1:0] LAST_L = LYR_W'(LAYERS - 1);
  localparam logic [COL_W-1:0] LAST_C = COL_W'(COLS - 1);

  state_t           state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [LYR_W-1:0] lyr_r, lyr_nxt, l_r, l_nxt;
  logic [1:0]       rin_r, rin_nxt;
  logic [4:0]       cin_r, cin_nxt;
  logic [7:0]       code_r, code_nxt;
  logic             on_r, on_nxt, blk_r, blk_nxt;
  logic             row_r, row_nxt, skip_r, skip_nxt, bad_r, bad_nxt;
  logic             line_r, line_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             lok, rok, cok;

  assign lok = {1'b0, lyr_r} < (LYR_W + 1)'(LAYERS);
  assign rok = (rin_r == 2'd1) || (rin_r == 2'd2);
  assign cok = (cin_r != 5'd0) && (COL_W'(cin_r) <= COL_W'(COLS));

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;  lyr_nxt = lyr_r;  rin_nxt = rin_r;  cin_nxt = cin_r;
    code_nxt = code_r;  on_nxt = on_r;  blk_nxt = blk_r;
    l_nxt = l_r;  row_nxt = row_r;  col_nxt = col_r;
    skip_nxt = skip_r;  bad_nxt = bad_r;  line_nxt = line_r;
    in_tready = 1'b0;

    cmd           = '0;
    cmd.wsrc      = WS_INIT;
    cmd.hid_op    = HID_NONE;
    cmd.kind      = EK_STATUS;
    cmd.lyr       = l_r;
    cmd.row       = row_r;
    cmd.col       = col_r;
    cmd.code      = code_r;
    cmd.cur_on    = on_r;
    cmd.cur_blink = blk_r;

    case (state_r)
      S_INIT: begin
        cmd.lm_wr   = 1'b1;
        cmd.sh_wr   = (l_r == '0);
        cmd.sh_init = 1'b1;
        if (col_r == LAST_C) begin
          col_nxt = '0;
          row_nxt = ~row_r;
          if (row_r) begin
            l_nxt = l_r + 1'b1;
            if (l_r == LAST_L) state_nxt = S_IDLE;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt   = in_tdata[2:0];
          lyr_nxt  = in_tdata[5:3];
          rin_nxt  = in_tdata[7:6];
          cin_nxt  = in_tdata[12:8];
          code_nxt = in_tdata[20:13];
          on_nxt   = in_tdata[21];
          blk_nxt  = in_tdata[22];
          row_nxt  = 1'b0;
          col_nxt  = '0;
          if (in_tdata[2:0] == CMD_REFRESH) begin
            cmd.cur_upd = 1'b1;
            state_nxt   = S_RADDR;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        cmd.lyr   = lyr_r;
        cmd.row   = (rin_r == 2'd2);
        cmd.col   = COL_W'(cin_r) - 1'b1;
        l_nxt     = lyr_r;
        state_nxt = S_STAT;
        bad_nxt   = 1'b0;
        case (op_r)
          CMD_WRITE: begin
            if (lok && rok && cok) begin
              cmd.lm_wr = 1'b1;
              cmd.wsrc  = WS_CODE;
            end else bad_nxt = 1'b1;
          end
          CMD_SET_CUR: begin
            if (lok && rok && cok) cmd.cur_wr = 1'b1;
            else bad_nxt = 1'b1;
          end
          CMD_CLR_LYR: begin
            if (lok) begin
              line_nxt  = 1'b0;
              row_nxt   = 1'b0;
              state_nxt = S_CLR;
            end else bad_nxt = 1'b1;
          end
          CMD_CLR_LN: begin
            if (lok && rok) begin
              line_nxt  = 1'b1;
              row_nxt   = (rin_r == 2'd2);
              state_nxt = S_CLR;
            end else bad_nxt = 1'b1;
          end
          CMD_HIDE:   if (lok) cmd.hid_op = HID_SET;  else bad_nxt = 1'b1;
          CMD_SHOW:   if (lok) cmd.hid_op = HID_CLR;  else bad_nxt = 1'b1;
          CMD_TOGGLE: if (lok) cmd.hid_op = HID_FLIP; else bad_nxt = 1'b1;
          default:    bad_nxt = 1'b1;
        endcase
      end
      S_CLR: begin
        cmd.lm_wr = 1'b1;
        cmd.wsrc  = WS_TRANS;
        if (col_r == LAST_C) begin
          col_nxt = '0;
          if (line_r || row_r) state_nxt = S_STAT;
          else row_nxt = 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_STAT: begin
        if (!stat.busy) begin
          cmd.emit   = 1'b1;
          cmd.status = bad_r;
          cmd.last   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RADDR: begin
        if (!stat.busy) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_ROWADDR;
          skip_nxt  = 1'b0;
          l_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.lm_rd = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_first = (l_r == '0);
        if (l_r == LAST_L) begin
          state_nxt = S_CMP;
        end else begin
          l_nxt     = l_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_CMP: begin
        if (stat.diff) state_nxt = skip_r ? S_SKIPA : S_DATA;
        else begin
          skip_nxt  = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_SKIPA: begin
        if (!stat.busy) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_ADDR;
          skip_nxt  = 1'b0;
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        if (!stat.busy) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_DATA;
          cmd.sh_wr = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        l_nxt = '0;
        if (col_r == LAST_C) begin
          col_nxt = '0;
          if (row_r) state_nxt = S_CUR;
          else begin
            row_nxt   = 1'b1;
            state_nxt = S_RADDR;
          end
        end else begin
          col_nxt   = col_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_CUR: begin
        if (!stat.busy) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_CURSOR;
          state_nxt = S_MODE;
        end
      end
      S_MODE: begin
        if (!stat.busy) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_MODE;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      l_r     <= '0;
      row_r   <= 1'b0;
      col_r   <= '0;
      skip_r  <= 1'b0;
      bad_r   <= 1'b0;
      line_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      l_r     <= l_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      skip_r  <= skip_nxt;
      bad_r   <= bad_nxt;
      line_r  <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    lyr_r  <= lyr_nxt;
    rin_r  <= rin_nxt;
    cin_r  <= cin_nxt;
    code_r <= code_nxt;
    on_r   <= on_nxt;
    blk_r  <= blk_nxt;
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !stat.busy) else $error("word issued into a full output register");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= LAST_C) else $error("column counter out of range");
  a_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.lm_rd && cmd.lm_wr)) else $error("layer memory read and write together");
  a_compose_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && l_r == LAST_L) |=> state_r == S_CMP)
    else $error("compare did not follow last layer");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the layered character compositor: directed edits
// and refreshes, then random traffic under several idling phases, checked
// beat by beat against a local model of layers, shown text and cursor.
// ----------------------------------------------------------------------------
class lcd_scoreboard;
  localparam int NL = 4;
  localparam int NC = 16;

  logic [7:0] trans;
  logic [7:0] chars [NL][2][NC];
  logic       hidden [NL];
  logic       crow [NL];
  logic [4:0] ccol [NL];
  logic       con [NL];
  logic       cblink [NL];
  logic [7:0] shown [2][NC];
  logic       comp_row;
  logic [4:0] comp_col;
  logic [11:0] pending_words [$];
  int errors;

  function new();
    trans = 8'h20;
    for (int l = 0; l < NL; l++) begin
      for (int r = 0; r < 2; r++)
        for (int c = 0; c < NC; c++) chars[l][r][c] = 8'h20;
      hidden[l] = 0; crow[l] = 0; ccol[l] = 0; con[l] = 0; cblink[l] = 0;
    end
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < NC; c++) shown[r][c] = 8'h20;
    comp_row = 0; comp_col = 0; errors = 0;
  endfunction

  function void set_trans(logic [7:0] v);
    trans = v;
  endfunction

  // word[8:0] valid[9] status[10] last[11]
  function void push(logic [8:0] w, logic v, logic s);
    pending_words.push_back({1'b0, s, v, w});
  endfunction

  function void note_input(logic [22:0] d);
    logic [2:0] cmd, lyr;
    logic [1:0] row;
    logic [4:0] col;
    logic [7:0] code;
    logic [7:0] comp [2][NC];
    logic on, blink, lok, rok, cok, bad, skip;
    logic [11:0] t;
    cmd = d[2:0]; lyr = d[5:3]; row = d[7:6]; col = d[12:8];
    code = d[20:13]; on = d[21]; blink = d[22];
    lok = lyr < NL; rok = row == 1 || row == 2; cok = col >= 1 && col <= NC;
    bad = 0;
    case (cmd)
      lcc_pkg::CMD_WRITE:
        if (lok && rok && cok) chars[lyr][row-1][col-1] = code; else bad = 1;
      lcc_pkg::CMD_CLR_LYR:
        if (lok) begin
          for (int r = 0; r < 2; r++)
            for (int c = 0; c < NC; c++) chars[lyr][r][c] = trans;
        end else bad = 1;
      lcc_pkg::CMD_CLR_LN:
        if (lok && rok) begin
          for (int c = 0; c < NC; c++) chars[lyr][row-1][c] = trans;
        end else bad = 1;
      lcc_pkg::CMD_SET_CUR:
        if (lok && rok && cok) begin
          crow[lyr] = row - 1; ccol[lyr] = col - 1; con[lyr] = on; cblink[lyr] = blink;
        end else bad = 1;
      lcc_pkg::CMD_HIDE:   if (lok) hidden[lyr] = 1; else bad = 1;
      lcc_pkg::CMD_SHOW:   if (lok) hidden[lyr] = 0; else bad = 1;
      lcc_pkg::CMD_TOGGLE: if (lok) hidden[lyr] = !hidden[lyr]; else bad = 1;
      default: begin
        on = 0; blink = 0;
        for (int r = 0; r < 2; r++)
          for (int c = 0; c < NC; c++) comp[r][c] = trans;
        for (int l = 0; l < NL; l++) begin
          if (!hidden[l]) begin
            for (int r = 0; r < 2; r++)
              for (int c = 0; c < NC; c++)
                if (chars[l][r][c] != trans) comp[r][c] = chars[l][r][c];
            comp_row = crow[l]; comp_col = ccol[l]; on = con[l]; blink = cblink[l];
          end
        end
        for (int r = 0; r < 2; r++) begin
          push(lcc_pkg::DD_ADDR | (r ? 9'h040 : 9'h000), 1, 0);
          skip = 0;
          for (int c = 0; c < NC; c++) begin
            if (shown[r][c] != comp[r][c]) begin
              if (skip) begin
                push(lcc_pkg::DD_ADDR | ((r ? 9'h040 : 9'h000) + 9'(c)), 1, 0);
                skip = 0;
              end
              push(lcc_pkg::DATA_RS | 9'(comp[r][c]), 1, 0);
              shown[r][c] = comp[r][c];
            end else skip = 1;
          end
        end
        push(lcc_pkg::DD_ADDR | ((comp_row ? 9'h040 : 9'h000) + 9'(comp_col)), 1, 0);
        push(lcc_pkg::ON_OFF | lcc_pkg::DISP_ON | {7'd0, on, blink}, 1, 0);
      end
    endcase
    if (cmd != lcc_pkg::CMD_REFRESH) push(9'd0, 0, bad);
    t = pending_words.pop_back();
    t[11] = 1;
    pending_words.push_back(t);
  endfunction

  function void check_result(logic [15:0] d, logic lst);
    logic [11:0] e;
    if (pending_words.size() == 0) begin
      $error("unexpected beat %h", d); errors++; return;
    end
    e = pending_words.pop_front();
    if (d[8:0] !== e[8:0]) begin
      $error("lcd_word exp %h got %h", e[8:0], d[8:0]); errors++;
    end
    if (d[9] !== e[9]) begin
      $error("word_valid exp %b got %b", e[9], d[9]); errors++;
    end
    if (d[10] !== e[10]) begin
      $error("status exp %b got %b", e[10], d[10]); errors++;
    end
    if (lst !== e[11]) begin
      $error("last exp %b got %b", e[11], lst); errors++;
    end
  endfunction
endclass

module tb;
  import lcc_pkg::*;

  logic clk, rst_n, cfg_we;
  logic [7:0] cfg_wdata;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tlast;
  logic [23:0] in_tdata;
  logic [15:0] out_tdata;

  lcd_scoreboard sb;
  int send_idle, recv_stall, quiet_cycles;

  layered_char_lcd_compositor_top #(.LAYERS(4), .COLS(16)) uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver side with random stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb failed");
      $finish;
    end
  end

  // valid stays up between back-to-back beats; idling or drain() drops it
  task automatic send_item(logic [2:0] cmd, logic [2:0] lyr, logic [1:0] row,
                           logic [4:0] col, logic [7:0] code, logic on, logic blink);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {1'b0, blink, on, code, col, row, lyr, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(in_tdata[22:0]);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_trans(logic [7:0] v);
    drain();
    cfg_we <= 1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_trans(v);
  endtask

  task automatic random_item(logic [7:0] tr);
    int k;
    logic [2:0] cmd;
    logic [7:0] code;
    k = $urandom_range(99);
    if (k < 35) cmd = CMD_WRITE;
    else if (k < 45) cmd = CMD_SET_CUR;
    else if (k < 70) cmd = 3'($urandom_range(1, 6));
    else cmd = ($urandom_range(3) == 0) ? CMD_REFRESH : CMD_WRITE;
    code = ($urandom_range(4) == 0) ? tr : 8'($urandom);
    if ($urandom_range(9) == 0)
      send_item(cmd, 3'($urandom), 2'($urandom), 5'($urandom), code,
                1'($urandom), 1'($urandom));
    else
      send_item(cmd, 3'($urandom_range(3)), 2'($urandom_range(1, 2)),
                5'($urandom_range(1, 16)), code, 1'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [7:0] tv [4];
    sb = new();
    rst_n = 0; cfg_we = 0; cfg_wdata = 0; in_tvalid = 0; in_tdata = 0;
    out_tready = 0; send_idle = 0; recv_stall = 0; quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed
    send_item(CMD_REFRESH, 0, 0, 0, 0, 0, 0);
    send_item(CMD_WRITE, 0, 1, 1, 8'h41, 0, 0);
    send_item(CMD_WRITE, 3, 2, 16, 8'hFF, 0, 0);
    send_item(CMD_WRITE, 1, 1, 5, 8'h00, 0, 0);
    send_item(CMD_WRITE, 7, 3, 31, 8'hAA, 1, 1);
    send_item(CMD_WRITE, 0, 0, 1, 8'h42, 0, 0);
    send_item(CMD_WRITE, 0, 1, 0, 8'h42, 0, 0);
    send_item(CMD_WRITE, 0, 2, 17, 8'h42, 0, 0);
    send_item(CMD_SET_CUR, 2, 2, 16, 0, 1, 1);
    send_item(CMD_SET_CUR, 4, 1, 1, 0, 1, 0);
    send_item(CMD_SET_CUR, 1, 3, 1, 0, 0, 1);
    send_item(CMD_REFRESH, 7, 3, 31, 8'hFF, 1, 1);
    send_item(CMD_REFRESH, 0, 0, 0, 0, 0, 0);
    send_item(CMD_HIDE, 3, 0, 0, 0, 0, 0);
    send_item(CMD_TOGGLE, 2, 0, 0, 0, 0, 0);
    send_item(CMD_SHOW, 5, 0, 0, 0, 0, 0);
    send_item(CMD_REFRESH, 0, 0, 0, 0, 0, 0);
    send_item(CMD_HIDE, 0, 0, 0, 0, 0, 0);
    send_item(CMD_HIDE, 1, 0, 0, 0, 0, 0);
    send_item(CMD_HIDE, 2, 0, 0, 0, 0, 0);
    send_item(CMD_REFRESH, 0, 0, 0, 0, 0, 0); // nothing visible
    send_item(CMD_SHOW, 0, 0, 0, 0, 0, 0);
    send_item(CMD_CLR_LN, 0, 1, 0, 0, 0, 0);
    send_item(CMD_CLR_LN, 0, 3, 0, 0, 0, 0);
    send_item(CMD_CLR_LYR, 3, 0, 0, 0, 0, 0);
    send_item(CMD_CLR_LYR, 6, 0, 0, 0, 0, 0);
    send_item(CMD_REFRESH, 0, 0, 0, 0, 0, 0);

    tv[0] = 8'h00; tv[1] = 8'hFF; tv[2] = 8'($urandom); tv[3] = 8'h20;
    for (int ph = 0; ph < 4; ph++) begin
      write_trans(tv[ph]);
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 49; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 49; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      for (int i = 0; i < 75; i++) random_item(tv[ph]);
      send_item(CMD_REFRESH, 0, 0, 0, 0, 0, 0);
    end

    drain();
    if (sb.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
